// ===== rtl/c2c_pkg.sv =====
// Package: types, constants and helpers for the curvilinear to Cartesian core.
package c2c_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518853;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    typedef enum logic [2:0] {
        MODE_CART      = 3'd0,
        MODE_POLAR     = 3'd1,
        MODE_CYL       = 3'd2,
        MODE_SPH_SURF  = 3'd3,
        MODE_SPH_VOL   = 3'd4,
        MODE_TOR_SURF  = 3'd5,
        MODE_TOR_VOL   = 3'd6,
        MODE_SPARE     = 3'd7
    } t_mode;

    localparam logic [2:0] REG_VIEW   = 3'd0;
    localparam logic [2:0] REG_SCALE  = 3'd1;
    localparam logic [2:0] REG_CX     = 3'd2;
    localparam logic [2:0] REG_CY     = 3'd3;
    localparam logic [2:0] REG_CZ     = 3'd4;
    localparam logic [2:0] REG_TORUS  = 3'd5;
    localparam logic [2:0] REG_ROFF   = 3'd6;
    localparam logic [2:0] REG_RSPAN  = 3'd7;

    typedef struct packed {
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [31:0] height_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out_item;

    // CORDIC rotator state carried cell to cell
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } t_rot;

    function automatic logic signed [35:0] atan_q30(input int i);
        unique case (i)
            0: atan_q30 = 36'sd843314857;
            1: atan_q30 = 36'sd497837829;
            2: atan_q30 = 36'sd263043837;
            3: atan_q30 = 36'sd133525159;
            4: atan_q30 = 36'sd67021687;
            5: atan_q30 = 36'sd33543516;
            6: atan_q30 = 36'sd16775851;
            7: atan_q30 = 36'sd8388437;
            8: atan_q30 = 36'sd4194283;
            9: atan_q30 = 36'sd2097149;
            default: atan_q30 = 36'sd1 <<< (30 - i);
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) sat32 = 32'sh7FFFFFFF;
        else if (v < -96'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

endpackage

// ===== rtl/c2c_cordic_cell.sv =====
// One CORDIC rotation cell: a registered micro-rotation passed to the next cell.
module c2c_cordic_cell
    import c2c_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  t_rot i_rot,
    output t_rot o_rot
);
    localparam logic signed [35:0] ATAN = atan_q30(STAGE);

    t_rot r_rot;
    t_rot n_rot;
    logic signed [35:0] w_z;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[33]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y + (i_rot.x >>> STAGE);
            w_z     = 36'(i_rot.z) - ATAN;
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y - (i_rot.x >>> STAGE);
            w_z     = 36'(i_rot.z) + ATAN;
        end
        n_rot.z = w_z[33:0];
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_rot = r_rot;
endmodule

// ===== rtl/c2c_sincos.sv =====
// Angle reduction followed by a chain of CORDIC cells giving sine and cosine in Q3.30.
module c2c_sincos
    import c2c_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_ang,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0] TWO_PI_Q =
        (TWO_PI_Q30 + (36'sd1 <<< (SH - 1))) >>> SH;
    localparam int N = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int RK = FRAC_BITS + 34;
    localparam logic [63:0] RECIP = (64'd1 << RK) / 64'(TWO_PI_Q);

    // reduce modulo two pi: reciprocal estimate of the quotient, then one correction
    logic signed [31:0] r_ang;
    logic signed [31:0] r_quo;
    logic signed [35:0] r_red;
    t_rot               r_seed;
    logic signed [64:0] w_prod;
    logic signed [63:0] w_rem;
    logic signed [35:0] n_red;
    logic signed [35:0] w_z;
    t_rot               n_seed;

    always_comb begin
        w_prod = i_ang * $signed({1'b0, RECIP[31:0]});
        w_rem  = 64'(r_ang) - r_quo * $signed(TWO_PI_Q[31:0]);
        n_red  = w_rem[35:0];
        if (w_rem < 0) n_red = w_rem[35:0] + TWO_PI_Q;
        else if (w_rem >= 64'(TWO_PI_Q)) n_red = w_rem[35:0] - TWO_PI_Q;
        w_z = r_red <<< SH;
        if (w_z >= PI_Q30) w_z = w_z - TWO_PI_Q30;
        n_seed.neg = 1'b0;
        if (w_z > HALF_PI_Q30) begin
            w_z = w_z - PI_Q30;
            n_seed.neg = 1'b1;
        end else if (w_z < -HALF_PI_Q30) begin
            w_z = w_z + PI_Q30;
            n_seed.neg = 1'b1;
        end
        n_seed.x = GAIN_Q30[33:0];
        n_seed.y = '0;
        n_seed.z = w_z[33:0];
    end

    always_ff @(posedge i_clk) begin
        r_ang  <= i_ang;
        r_quo  <= 32'(w_prod >>> RK);
        r_red  <= n_red;
        r_seed <= n_seed;
    end

    t_rot w_chain [N+1];
    assign w_chain[0] = r_seed;

    for (genvar g = 0; g < N; g++) begin : g_cell
        c2c_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_rot (w_chain[g]),
            .o_rot (w_chain[g+1])
        );
    end

    assign o_cos = w_chain[N].neg ? -w_chain[N].x : w_chain[N].x;
    assign o_sin = w_chain[N].neg ? -w_chain[N].y : w_chain[N].y;
endmodule

// ===== rtl/c2c_delay.sv =====
// Shift line of registers that keeps side data aligned with the CORDIC chain.
module c2c_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) r_tap[i] <= r_tap[i-1];
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

// ===== rtl/curvilinear_to_cartesian_core.sv =====
// Top level of the curvilinear to Cartesian core: registers, scaling, CORDIC and product stages.
// Throughput: one item per cycle; busy is held low, the CORDIC cell chain is fully pipelined.
// Results are shown for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) clears the valid line and loads register defaults.
// Configuration registers are read back over the APB-style port.
module curvilinear_to_cartesian_core
    import c2c_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NC  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int CL  = NC + 3;
    localparam int LAT = CL + 6;
    localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

    logic [4:0]         r_view;
    logic [30:0]        r_scale;
    logic signed [31:0] r_cx, r_cy, r_cz, r_tor, r_roff, r_rspan;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view  <= '0;
            r_scale <= 31'(64'sd1 <<< FRAC_BITS);
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
            r_tor   <= '0;
            r_roff  <= '0;
            r_rspan <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_VIEW:  r_view  <= pwdata[4:0];
                REG_SCALE: r_scale <= pwdata[30:0];
                REG_CX:    r_cx    <= pwdata;
                REG_CY:    r_cy    <= pwdata;
                REG_CZ:    r_cz    <= pwdata;
                REG_TORUS: r_tor   <= pwdata;
                REG_ROFF:  r_roff  <= pwdata;
                REG_RSPAN: r_rspan <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_VIEW:  prdata = {27'd0, r_view};
            REG_SCALE: prdata = {1'b0, r_scale};
            REG_CX:    prdata = r_cx;
            REG_CY:    prdata = r_cy;
            REG_CZ:    prdata = r_cz;
            REG_TORUS: prdata = r_tor;
            REG_ROFF:  prdata = r_roff;
            REG_RSPAN: prdata = r_rspan;
        endcase
    end

    t_mode w_mode;
    logic  w_vh, w_hz;
    assign w_mode = t_mode'(r_view[2:0]);
    assign w_vh   = r_view[3];
    assign w_hz   = r_view[4];

    // stage 1: centered differences, raw height product
    logic signed [31:0] r_da, r_db, r_dc, r_a, r_hp;
    logic signed [31:0] r_ang0, r_ang1;
    logic               r_v1;
    logic signed [31:0] n_ang0, n_ang1;
    logic signed [63:0] w_hprod;

    always_comb begin
        unique case (w_mode)
            MODE_POLAR, MODE_CYL: begin
                n_ang0 = i_item.coord_b;
                n_ang1 = i_item.coord_b;
            end
            MODE_SPH_SURF, MODE_TOR_SURF: begin
                n_ang0 = i_item.coord_a;
                n_ang1 = i_item.coord_b;
            end
            MODE_SPH_VOL, MODE_TOR_VOL: begin
                n_ang0 = i_item.coord_b;
                n_ang1 = i_item.coord_c;
            end
            default: begin
                n_ang0 = i_item.coord_a;
                n_ang1 = i_item.coord_b;
            end
        endcase
        w_hprod = i_item.height_value * r_rspan;
    end

    always_ff @(posedge i_clk) begin
        r_da   <= sat32(96'(i_item.coord_a) - 96'(r_cx));
        r_db   <= sat32(96'(i_item.coord_b) - 96'(r_cy));
        r_dc   <= sat32(96'(i_item.coord_c) - 96'(r_cz));
        r_a    <= i_item.coord_a;
        r_hp   <= sat32(96'((w_hprod + HALF_Q) >>> FRAC_BITS));
        r_ang0 <= n_ang0;
        r_ang1 <= n_ang1;
    end

    // stage 2: scale products, height term
    logic signed [31:0] r_sx, r_sy, r_sz, r_sa, r_h;
    logic signed [63:0] w_sx, w_sy, w_sz, w_sa;
    assign w_sx = r_da * $signed({1'b0, r_scale});
    assign w_sy = r_db * $signed({1'b0, r_scale});
    assign w_sz = r_dc * $signed({1'b0, r_scale});
    assign w_sa = r_a  * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        r_sx <= sat32(96'((w_sx + HALF_Q) >>> FRAC_BITS));
        r_sy <= sat32(96'((w_sy + HALF_Q) >>> FRAC_BITS));
        r_sz <= sat32(96'((w_sz + HALF_Q) >>> FRAC_BITS));
        r_sa <= sat32(96'((w_sa + HALF_Q) >>> FRAC_BITS));
        r_h  <= sat32(96'(r_roff) + 96'(r_hp));
    end

    // result selection per mode at stage 2 output
    logic signed [31:0] w_r, w_cx, w_cy, w_cz;
    always_comb begin
        w_r  = r_sa;
        w_cx = r_sx;
        w_cy = r_sy;
        w_cz = w_hz ? r_sz : r_h;
        unique case (w_mode)
            MODE_POLAR:    w_cz = w_vh ? r_h : (w_hz ? r_sz : 32'sd0);
            MODE_CYL:      w_cz = r_sz;
            MODE_SPH_SURF: w_r  = r_h;
            MODE_TOR_SURF: w_r  = r_h;
            default:       w_r  = r_sa;
        endcase
    end

    // trig for both angles; inputs from stage 1, so a delay line aligns them with the side data
    logic signed [31:0] w_ang0, w_ang1;
    logic signed [33:0] w_s0, w_c0, w_s1, w_c1;
    c2c_delay #(.WIDTH(64), .DEPTH(2)) u_dang (
        .i_clk (i_clk),
        .i_d   ({r_ang0, r_ang1}),
        .o_q   ({w_ang0, w_ang1})
    );

    c2c_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_trig0 (
        .i_clk (i_clk), .i_ang (w_ang0), .o_sin (w_s0), .o_cos (w_c0)
    );
    c2c_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_trig1 (
        .i_clk (i_clk), .i_ang (w_ang1), .o_sin (w_s1), .o_cos (w_c1)
    );

    // side data: radius, Cartesian results, mode; align to trig output
    logic signed [31:0] w_dr, w_dx, w_dy, w_dz;
    logic [2:0]         w_dm;
    c2c_delay #(.WIDTH(131), .DEPTH(CL + 1)) u_dside (
        .i_clk (i_clk),
        .i_d   ({w_r, w_cx, w_cy, w_cz, r_view[2:0]}),
        .o_q   ({w_dr, w_dx, w_dy, w_dz, w_dm})
    );

    // product stage A: r*cos0, r*sin0, r*sin1, r*cos1
    logic signed [31:0] r_rc0, r_rs0, r_rs1, r_rc1;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [33:0] r_s0, r_c0, r_s1, r_c1;
    logic [2:0]         r_pm;
    logic signed [65:0] w_m0, w_m1, w_m2, w_m3;
    assign w_m0 = w_dr * w_c0;
    assign w_m1 = w_dr * w_s0;
    assign w_m2 = w_dr * w_s1;
    assign w_m3 = w_dr * w_c1;

    always_ff @(posedge i_clk) begin
        r_rc0 <= sat32(96'((w_m0 + 66'sd536870912) >>> 30));
        r_rs0 <= sat32(96'((w_m1 + 66'sd536870912) >>> 30));
        r_rs1 <= sat32(96'((w_m2 + 66'sd536870912) >>> 30));
        r_rc1 <= sat32(96'((w_m3 + 66'sd536870912) >>> 30));
        r_s0 <= w_s0;  r_c0 <= w_c0;  r_s1 <= w_s1;  r_c1 <= w_c1;
        r_px <= w_dx;  r_py <= w_dy;  r_pz <= w_dz;  r_pm <= w_dm;
    end

    // stage B: ring, choose second multiplicand
    logic signed [31:0] r_t, r_bx, r_by, r_bz, r_rc0b, r_rs0b, r_rc1b, r_rs0c;
    logic signed [33:0] r_bs0, r_bc0, r_bs1, r_bc1;
    logic [2:0]         r_bm;
    always_ff @(posedge i_clk) begin
        r_t  <= (t_mode'(r_pm) == MODE_TOR_SURF || t_mode'(r_pm) == MODE_TOR_VOL)
                ? sat32(96'(r_tor) + 96'(r_rc0)) : r_rs1;
        r_bs0 <= r_s0; r_bc0 <= r_c0; r_bs1 <= r_s1; r_bc1 <= r_c1;
        r_bx <= r_px; r_by <= r_py; r_bz <= r_pz; r_bm <= r_pm;
        r_rc0b <= r_rc0; r_rs0b <= r_rs0; r_rc1b <= r_rc1; r_rs0c <= r_rs0;
    end

    // stage C: second products
    logic signed [33:0] w_fx, w_fy;
    logic signed [65:0] w_qx, w_qy;
    logic               w_tor;
    assign w_tor = (t_mode'(r_bm) == MODE_TOR_SURF || t_mode'(r_bm) == MODE_TOR_VOL);
    assign w_fx  = w_tor ? r_bc1 : r_bc0;
    assign w_fy  = w_tor ? r_bs1 : r_bs0;
    assign w_qx  = r_t * w_fx;
    assign w_qy  = r_t * w_fy;

    t_out_item r_out, n_out;
    always_comb begin
        unique case (t_mode'(r_bm))
            MODE_POLAR, MODE_CYL: begin
                n_out.out_x = r_rc0b;
                n_out.out_y = r_rs0b;
                n_out.out_z = r_bz;
            end
            MODE_SPH_SURF, MODE_SPH_VOL: begin
                n_out.out_x = sat32(96'((w_qx + 66'sd536870912) >>> 30));
                n_out.out_y = sat32(96'((w_qy + 66'sd536870912) >>> 30));
                n_out.out_z = r_rc1b;
            end
            MODE_TOR_SURF, MODE_TOR_VOL: begin
                n_out.out_x = sat32(96'((w_qx + 66'sd536870912) >>> 30));
                n_out.out_y = sat32(96'((w_qy + 66'sd536870912) >>> 30));
                n_out.out_z = r_rs0c;
            end
            default: begin
                n_out.out_x = r_bx;
                n_out.out_y = r_by;
                n_out.out_z = r_bz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // valid line
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[LAT-2:0], start};
    end
    assign r_v1    = r_vld[0];
    assign o_valid = r_vld[LAT-1];
    assign o_item  = r_out;

    a_busy_low: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ##(LAT-1) o_valid)
        else $error("item lost in pipe");
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without item");
endmodule
